FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge while out of reset
`define BTR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset cycles included
`define BTR_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/btr_pkg.sv
package btr_pkg;

  // fixed field widths
  localparam int COORD_W   = 11;
  localparam int CFG_W     = 10;
  localparam int SCALE_W   = 3;
  localparam int MASK_W    = 32;
  localparam int RWIDTH_W  = 6;
  localparam int CMD_W     = 2;
  localparam int CODE_W    = 8;
  localparam int FADDR_W   = 12;
  localparam int BYTE_W    = 8;
  localparam int REG_IDX_W = 3;

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WRAP    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SCALE   = 3'd5;

  // text window settings seen by the cursor unit
  typedef struct packed {
    logic [CFG_W-1:0] start_x;
    logic [CFG_W-1:0] start_y;
    logic [CFG_W-1:0] limit_x;
    logic [CFG_W-1:0] limit_y;
    logic             wrap;
  } cfg_t;

  // cursor commands from the sequencer
  typedef struct packed {
    logic start;
    logic step;
  } cur_ctl_t;

  // cursor status back to the sequencer
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               halted;
  } cur_stat_t;

endpackage

FILE: rtl/bitmap_text_rasterizer.sv
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+-----------------------------------------
// in       | input     | in_valid / in_stall    | command, char_code, font_address, font_byte
// out      | output    | out_valid / out_stall  | pixel_x, pixel_y, row_mask, row_width,
//          |           |                        | last_row, text_halted
// cfg      | input     | cfg_write              | cfg_index, cfg_data
//
// load, begin and halted draw beats leave the sequencer idle, so in is not stalled after them.
// a drawn character is sequenced glyph row by glyph row:
// each glyph row needs two reads through the single font memory read port and a
// mask stage, then one scaled row per cycle through the output register while out is not stalled.
// rst_n is synchronous, active low; the font memory is not cleared and holds
// whatever was last loaded.
// out_stall holds the row emitter; the next in beat is taken while the final row waits.
module bitmap_text_rasterizer #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 12,
  parameter int GLYPH_COUNT  = 256,
  parameter int MAX_SCALE    = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write,
  input  logic [btr_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [btr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [btr_pkg::CMD_W-1:0]     in_command,
  input  logic [btr_pkg::CODE_W-1:0]    in_char_code,
  input  logic [btr_pkg::FADDR_W-1:0]   in_font_address,
  input  logic [btr_pkg::BYTE_W-1:0]    in_font_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [btr_pkg::COORD_W-1:0]   out_pixel_x,
  output logic [btr_pkg::COORD_W-1:0]   out_pixel_y,
  output logic [btr_pkg::MASK_W-1:0]    out_row_mask,
  output logic [btr_pkg::RWIDTH_W-1:0]  out_row_width,
  output logic                          out_last_row,
  output logic                          out_text_halted
);
  import btr_pkg::*;

  localparam int BPG        = (GLYPH_WIDTH * GLYPH_HEIGHT + 7) / 8;
  localparam int FONT_DEPTH = GLYPH_COUNT * BPG;
  localparam int AW         = (FONT_DEPTH > 1) ? $clog2(FONT_DEPTH) : 1;
  localparam int AW1        = AW + 1;
  localparam int PW         = $clog2(GLYPH_WIDTH * GLYPH_HEIGHT + 1);
  localparam int RW         = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
  localparam int BASE_PW    = CODE_W + 5;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_MASK = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]          state_r, state_nxt;

  // configuration registers
  logic [CFG_W-1:0]    start_x_r, start_y_r, limit_x_r, limit_y_r;
  logic                wrap_r;
  logic [SCALE_W-1:0]  scale_r;
  cfg_t                cfg;

  // per character working registers
  logic [SCALE_W-1:0]  sc_r, sc_nxt;
  logic [RWIDTH_W-1:0] width_r, width_nxt;
  logic [COORD_W-1:0]  x0_r, x0_nxt;
  logic [COORD_W-1:0]  yc_r, yc_nxt;
  logic [AW-1:0]       base_r, base_nxt;
  logic                blank_r, blank_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [SCALE_W-1:0]  rep_r, rep_nxt;
  logic [BYTE_W-1:0]   b0_r, b0_nxt;
  logic [MASK_W-1:0]   mask_r, mask_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0]  px_r, py_r;
  logic [MASK_W-1:0]   om_r;
  logic [RWIDTH_W-1:0] ow_r;
  logic                ol_r, oh_r;
  logic                out_load;

  logic                in_acc;
  logic [SCALE_W-1:0]  eff_sc;
  logic                code_ok;
  logic                last_rep, last_row;
  logic [AW1-1:0]      a0, a1;
  logic [AW-1:0]       rd_addr;
  logic [BYTE_W-1:0]   rd_data;
  logic                wr_en;
  logic [MASK_W-1:0]   exp_mask;
  cur_ctl_t            cur_ctl;
  cur_stat_t           cur_stat;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      limit_x_r <= CFG_W'(1023);
      limit_y_r <= CFG_W'(1023);
      wrap_r    <= 1'b1;
      scale_r   <= SCALE_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_X: start_x_r <= cfg_data;
        REG_START_Y: start_y_r <= cfg_data;
        REG_LIMIT_X: limit_x_r <= cfg_data;
        REG_LIMIT_Y: limit_y_r <= cfg_data;
        REG_WRAP:    wrap_r    <= cfg_data[0];
        REG_SCALE:   scale_r   <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.start_x = start_x_r;
  assign cfg.start_y = start_y_r;
  assign cfg.limit_x = limit_x_r;
  assign cfg.limit_y = limit_y_r;
  assign cfg.wrap    = wrap_r;

  // effective scale, zero taken as one and large values clamped
  always_comb begin
    if (scale_r == '0) begin
      eff_sc = SCALE_W'(1);
    end else if (scale_r > SCALE_W'(MAX_SCALE)) begin
      eff_sc = SCALE_W'(MAX_SCALE);
    end else begin
      eff_sc = scale_r;
    end
  end

  // font loads, out of range addresses dropped
  assign wr_en = in_acc && (in_command == CMD_LOAD) &&
                 ((FADDR_W+1)'(in_font_address) < (FADDR_W+1)'(FONT_DEPTH));

  // byte addresses for the current glyph row; the second byte is clamped at the
  // top of memory, its bits are never used there
  always_comb begin
    a0 = AW1'(base_r) + AW1'(pos_r >> 3);
    a1 = a0 + AW1'(1);
    if (a1 >= AW1'(FONT_DEPTH)) begin
      a1 = a0;
    end
    rd_addr = (state_r == S_RD1) ? a1[AW-1:0] : a0[AW-1:0];
  end

  btr_font_mem #(
    .DEPTH (FONT_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_font_address[AW-1:0]),
    .wr_data (in_font_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  btr_row_expand #(
    .GLYPH_WIDTH (GLYPH_WIDTH),
    .MAX_SCALE   (MAX_SCALE)
  ) u_expand (
    .byte_hi (b0_r),
    .byte_lo (rd_data),
    .offset  (3'(pos_r)),
    .scale   (sc_r),
    .blank   (blank_r),
    .mask    (exp_mask)
  );

  btr_cursor #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_cursor (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .ctl   (cur_ctl),
    .scale (eff_sc),
    .stat  (cur_stat)
  );

  assign code_ok  = (CODE_W+1)'(in_char_code) < (CODE_W+1)'(GLYPH_COUNT);
  assign last_rep = (rep_r == sc_r - SCALE_W'(1));
  assign last_row = (row_r == RW'(GLYPH_HEIGHT - 1));
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  // row sequencer
  always_comb begin
    state_nxt     = state_r;
    sc_nxt        = sc_r;
    width_nxt     = width_r;
    x0_nxt        = x0_r;
    yc_nxt        = yc_r;
    base_nxt      = base_r;
    blank_nxt     = blank_r;
    pos_nxt       = pos_r;
    row_nxt       = row_r;
    rep_nxt       = rep_r;
    b0_nxt        = b0_r;
    mask_nxt      = mask_r;
    cur_ctl.start = 1'b0;
    cur_ctl.step  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_command == CMD_BEGIN)) begin
          cur_ctl.start = 1'b1;
        end
        if (in_acc && (in_command == CMD_DRAW) && !cur_stat.halted) begin
          cur_ctl.step = 1'b1;
          sc_nxt       = eff_sc;
          width_nxt    = RWIDTH_W'(GLYPH_WIDTH) * RWIDTH_W'(eff_sc);
          x0_nxt       = cur_stat.x;
          yc_nxt       = cur_stat.y;
          base_nxt     = AW'(BASE_PW'(in_char_code) * BASE_PW'(BPG));
          blank_nxt    = !code_ok;
          pos_nxt      = '0;
          row_nxt      = '0;
          rep_nxt      = '0;
          state_nxt    = S_RD0;
        end
      end
      S_RD0: begin
        state_nxt = S_RD1;
      end
      S_RD1: begin
        b0_nxt    = rd_data;
        state_nxt = S_MASK;
      end
      S_MASK: begin
        mask_nxt  = exp_mask;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          yc_nxt = yc_r + COORD_W'(1);
          if (!last_rep) begin
            rep_nxt = rep_r + SCALE_W'(1);
          end else begin
            rep_nxt = '0;
            if (last_row) begin
              state_nxt = S_IDLE;
            end else begin
              row_nxt   = row_r + RW'(1);
              pos_nxt   = pos_r + PW'(GLYPH_WIDTH);
              state_nxt = S_RD0;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output beat holds until taken
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    sc_r    <= sc_nxt;
    width_r <= width_nxt;
    x0_r    <= x0_nxt;
    yc_r    <= yc_nxt;
    base_r  <= base_nxt;
    blank_r <= blank_nxt;
    pos_r   <= pos_nxt;
    row_r   <= row_nxt;
    rep_r   <= rep_nxt;
    b0_r    <= b0_nxt;
    mask_r  <= mask_nxt;
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      px_r <= x0_r;
      py_r <= yc_r;
      om_r <= mask_r;
      ow_r <= width_r;
      ol_r <= last_rep && last_row;
      oh_r <= cur_stat.halted;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_row_mask    = om_r;
  assign out_row_width   = ow_r;
  assign out_last_row    = ol_r;
  assign out_text_halted = oh_r;

endmodule

FILE: rtl/btr_font_mem.sv
module btr_font_mem #(
  parameter int DEPTH = 3072,
  parameter int AW    = 12
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [btr_pkg::BYTE_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [btr_pkg::BYTE_W-1:0] rd_data
);
  import btr_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // byte write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/btr_row_expand.sv
module btr_row_expand #(
  parameter int GLYPH_WIDTH = 8,
  parameter int MAX_SCALE   = 4
) (
  input  logic [btr_pkg::BYTE_W-1:0]  byte_hi,
  input  logic [btr_pkg::BYTE_W-1:0]  byte_lo,
  input  logic [2:0]                  offset,
  input  logic [btr_pkg::SCALE_W-1:0] scale,
  input  logic                        blank,
  output logic [btr_pkg::MASK_W-1:0]  mask
);
  import btr_pkg::*;

  localparam int WIN_W = 2 * BYTE_W;

  logic [WIN_W-1:0]       win;
  logic [GLYPH_WIDTH-1:0] bits;
  logic [MASK_W-1:0]      wide [1:MAX_SCALE];

  always_comb begin
    // align the glyph row to the top of the two byte window, msb first
    win = {byte_hi, byte_lo} << offset;
    for (int c = 0; c < GLYPH_WIDTH; c++) begin
      bits[c] = win[WIN_W-1-c];
    end
    // one widened copy per scale, each pixel repeated s times
    for (int s = 1; s <= MAX_SCALE; s++) begin
      wide[s] = '0;
      for (int c = 0; c < GLYPH_WIDTH; c++) begin
        for (int k = 0; k < s; k++) begin
          wide[s][c*s+k] = bits[c];
        end
      end
    end
    // pick the copy for the active scale
    mask = '0;
    for (int s = 1; s <= MAX_SCALE; s++) begin
      if (scale == SCALE_W'(s)) begin
        mask = wide[s];
      end
    end
    // codes outside the font draw nothing
    if (blank) begin
      mask = '0;
    end
  end

endmodule

FILE: rtl/btr_cursor.sv
module btr_cursor #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  btr_pkg::cfg_t               cfg,
  input  btr_pkg::cur_ctl_t           ctl,
  input  logic [btr_pkg::SCALE_W-1:0] scale,
  output btr_pkg::cur_stat_t          stat
);
  import btr_pkg::*;

  localparam int SUM_W = COORD_W + 1;

  logic [COORD_W-1:0] x_r, x_nxt;
  logic [COORD_W-1:0] y_r, y_nxt;
  logic               halted_r, halted_nxt;
  logic [SUM_W-1:0]   cw, ch, nx, nx2, ny;

  // next cursor position after a character
  always_comb begin
    cw  = SUM_W'(GLYPH_WIDTH) * SUM_W'(scale);
    ch  = SUM_W'(GLYPH_HEIGHT) * SUM_W'(scale);
    nx  = SUM_W'(x_r) + cw;
    nx2 = nx + cw;
    ny  = SUM_W'(y_r) + ch;

    x_nxt      = x_r;
    y_nxt      = y_r;
    halted_nxt = halted_r;

    if (ctl.start) begin
      x_nxt      = COORD_W'(cfg.start_x);
      y_nxt      = COORD_W'(cfg.start_y);
      halted_nxt = 1'b0;
    end else if (ctl.step) begin
      if (nx2 <= SUM_W'(cfg.limit_x)) begin
        x_nxt = COORD_W'(nx);
      end else if (!cfg.wrap) begin
        // single line: keep going while part of the next glyph still fits
        if (nx <= SUM_W'(cfg.limit_x)) begin
          x_nxt = COORD_W'(nx);
        end else begin
          halted_nxt = 1'b1;
        end
      end else if (ny > SUM_W'(cfg.limit_y)) begin
        halted_nxt = 1'b1;
      end else begin
        x_nxt = COORD_W'(cfg.start_x);
        y_nxt = COORD_W'(ny);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      y_r      <= '0;
      halted_r <= 1'b0;
    end else begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      halted_r <= halted_nxt;
    end
  end

  assign stat.x      = x_r;
  assign stat.y      = y_r;
  assign stat.halted = halted_r;

endmodule

FILE: rtl/btr_port_checker.sv
`include "assert_macros.svh"

module btr_port_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [btr_pkg::CMD_W-1:0]    in_command,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [btr_pkg::COORD_W-1:0]  out_pixel_x,
  input logic [btr_pkg::COORD_W-1:0]  out_pixel_y,
  input logic [btr_pkg::MASK_W-1:0]   out_row_mask,
  input logic [btr_pkg::RWIDTH_W-1:0] out_row_width,
  input logic                         out_last_row,
  input logic                         out_text_halted
);
  import btr_pkg::*;

  // a stalled row beat is held unchanged
  `BTR_ASSERT_RST(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_pixel_x) && $stable(out_pixel_y) && $stable(out_row_mask) && $stable(out_row_width) && $stable(out_last_row) && $stable(out_text_halted)), "stalled row beat changed")

  // no row beat straight after reset
  `BTR_ASSERT_ALL(a_rst_idle, clk, $past(!rst_n) |-> !out_valid, "row beat right after reset")

  // every row beat covers at least one pixel
  `BTR_ASSERT_RST(a_width_nz, clk, rst_n, out_valid |-> (out_row_width != '0), "row beat of zero width")

  // no foreground beyond the row width
  `BTR_ASSERT_RST(a_mask_fit, clk, rst_n, out_valid |-> ((out_row_mask >> out_row_width) == '0), "mask bits beyond row width")

  // load and begin beats never hold off the next beat
  `BTR_ASSERT_RST(a_cmd_quick, clk, rst_n, (in_valid && !in_stall && (in_command == CMD_LOAD || in_command == CMD_BEGIN)) |=> !in_stall, "stall after load or begin")

endmodule

bind bitmap_text_rasterizer btr_port_checker u_port_checker (.*);

FILE: verif/bitmap_text_rasterizer_tb.sv
`timescale 1ns / 1ps

module bitmap_text_rasterizer_tb;
  import btr_pkg::*;

  localparam int GW          = 8;
  localparam int GH          = 12;
  localparam int GLYPHS      = 256;
  localparam int SCALE_MAX   = 4;
  localparam int GLYPH_BYTES = (GW * GH + 7) / 8;
  localparam int FONT_BYTES  = GLYPHS * GLYPH_BYTES;
  localparam int ADDR_MAX    = (1 << FADDR_W) - 1;
  // settle time after every row is seen, covering any work still in flight
  localparam int SETTLE      = 100;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 1000000;

  // the one command code the block ignores
  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

  // glyph 0 rows: all on, all off, single edge pixels, alternating, halves, C3/3C, 81/7E
  localparam logic [GH*8-1:0] CORNER_GLYPH = 96'hFF00_8001_AA55_F00F_C33C_817E;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [CODE_W-1:0]  char_code;
    logic [FADDR_W-1:0] font_address;
    logic [BYTE_W-1:0]  font_byte;
  } beat_t;

  typedef struct packed {
    logic [COORD_W-1:0]  pixel_x;
    logic [COORD_W-1:0]  pixel_y;
    logic [MASK_W-1:0]   row_mask;
    logic [RWIDTH_W-1:0] row_width;
    logic                last_row;
    logic                text_halted;
  } row_t;

  logic                clk;
  logic                rst_n           = 1'b0;
  logic                cfg_write       = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index      = '0;
  logic [CFG_W-1:0]    cfg_data        = '0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command      = '0;
  logic [CODE_W-1:0]   in_char_code    = '0;
  logic [FADDR_W-1:0]  in_font_address = '0;
  logic [BYTE_W-1:0]   in_font_byte    = '0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [COORD_W-1:0]  out_pixel_x;
  logic [COORD_W-1:0]  out_pixel_y;
  logic [MASK_W-1:0]   out_row_mask;
  logic [RWIDTH_W-1:0] out_row_width;
  logic                out_last_row;
  logic                out_text_halted;

  // shadow of the block: font, cursor and window registers
  bit [BYTE_W-1:0]    font_img [FONT_BYTES];
  int                 cur_x = 0;
  int                 cur_y = 0;
  bit                 stopped = 1'b0;
  int                 win_start_x = 0;
  int                 win_start_y = 0;
  int                 win_limit_x = 1023;
  int                 win_limit_y = 1023;
  bit                 wrap_on = 1'b1;
  logic [SCALE_W-1:0] scale_reg = 3'd1;
  row_t               rows_due[$];

  // stimulus side: beats waiting to go, and which glyphs are fully loaded
  beat_t beats_to_send[$];
  bit    glyph_byte_set [FONT_BYTES];
  bit    code_ready [GLYPHS];
  int    ready_codes[$];

  // pacing shared between the stimulus and the two handshake processes
  bit    quiet = 1'b0;
  int    hold_kick = 0;
  int    hold_seen = 0;
  int    hold_left = 0;
  int    stall_left = 0;
  int    flow_left = 0;
  int    gap_left = 0;
  int    run_left = 0;
  int    error_count = 0;
  int    cycles = 0;

  bitmap_text_rasterizer #(
    .GLYPH_WIDTH (GW),
    .GLYPH_HEIGHT(GH),
    .GLYPH_COUNT (GLYPHS),
    .MAX_SCALE   (SCALE_MAX)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_char_code   (in_char_code),
    .in_font_address(in_font_address),
    .in_font_byte   (in_font_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_row_mask   (out_row_mask),
    .out_row_width  (out_row_width),
    .out_last_row   (out_last_row),
    .out_text_halted(out_text_halted)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // rows that one accepted beat produces, and its effect on the shadow state
  task automatic glyph_rows_for(input beat_t b);
    int sc, x0, y0, cw, ch, nx, pos, addr;
    logic [MASK_W-1:0] mask;
    row_t r;
    case (b.command)
      CMD_LOAD: begin
        if (b.font_address < FONT_BYTES) font_img[b.font_address] = b.font_byte;
      end
      CMD_BEGIN: begin
        cur_x = win_start_x;
        cur_y = win_start_y;
        stopped = 1'b0;
      end
      CMD_DRAW: if (!stopped) begin
        sc = (scale_reg == 0) ? 1 : ((scale_reg > SCALE_MAX) ? SCALE_MAX : scale_reg);
        x0 = cur_x;
        y0 = cur_y;
        cw = GW * sc;
        ch = GH * sc;
        nx = cur_x + cw;
        // cursor step: advance, partial fit on one line, wrap, or halt
        if (nx + cw <= win_limit_x) begin
          cur_x = nx;
        end else if (!wrap_on) begin
          if (nx <= win_limit_x) cur_x = nx;
          else stopped = 1'b1;
        end else if (cur_y + ch > win_limit_y) begin
          stopped = 1'b1;
        end else begin
          cur_y = cur_y + ch;
          cur_x = win_start_x;
        end
        // msb-first glyph bits, each pixel widened and each row repeated by scale
        for (int row = 0; row < GH; row++) begin
          mask = '0;
          for (int col = 0; col < GW; col++) begin
            pos = col + row * GW;
            addr = b.char_code * GLYPH_BYTES + pos / 8;
            if (b.char_code < GLYPHS && addr < FONT_BYTES && font_img[addr][7 - pos % 8])
              for (int k = 0; k < sc; k++) mask[col * sc + k] = 1'b1;
          end
          for (int rep = 0; rep < sc; rep++) begin
            r.pixel_x     = COORD_W'(x0);
            r.pixel_y     = COORD_W'(y0 + row * sc + rep);
            r.row_mask    = mask;
            r.row_width   = RWIDTH_W'(GW * sc);
            r.last_row    = (row == GH - 1) && (rep == sc - 1);
            r.text_halted = stopped;
            rows_due.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_START_X: win_start_x = val;
      REG_START_Y: win_start_y = val;
      REG_LIMIT_X: win_limit_x = val;
      REG_LIMIT_Y: win_limit_y = val;
      REG_WRAP:    wrap_on = val[0];
      REG_SCALE:   scale_reg = val[SCALE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // whole window setup; unused upper data bits of the narrow registers are noise
  task automatic set_window(input int sx, input int sy, input int lx, input int ly,
                            input bit wrap, input logic [SCALE_W-1:0] sc);
    logic [CFG_W-1:0] noisy;
    write_reg(REG_START_X, CFG_W'(sx));
    write_reg(REG_START_Y, CFG_W'(sy));
    write_reg(REG_LIMIT_X, CFG_W'(lx));
    write_reg(REG_LIMIT_Y, CFG_W'(ly));
    noisy = CFG_W'($urandom);
    noisy[0] = wrap;
    write_reg(REG_WRAP, noisy);
    noisy = CFG_W'($urandom);
    noisy[SCALE_W-1:0] = sc;
    write_reg(REG_SCALE, noisy);
  endtask

  task automatic queue_beat(input logic [CMD_W-1:0] cmd, input int code, input int addr,
                            input int data);
    beat_t b;
    int g;
    bit full;
    b.command      = cmd;
    b.char_code    = CODE_W'(code);
    b.font_address = FADDR_W'(addr);
    b.font_byte    = BYTE_W'(data);
    beats_to_send.push_back(b);
    // a glyph becomes drawable once all of its bytes have been written
    if (cmd == CMD_LOAD && b.font_address < FONT_BYTES) begin
      glyph_byte_set[b.font_address] = 1'b1;
      g = b.font_address / GLYPH_BYTES;
      full = 1'b1;
      for (int i = 0; i < GLYPH_BYTES; i++) full &= glyph_byte_set[g * GLYPH_BYTES + i];
      if (full && !code_ready[g]) begin
        code_ready[g] = 1'b1;
        ready_codes.push_back(g);
      end
    end
  endtask

  task automatic queue_draw();
    queue_beat(CMD_DRAW, ready_codes[$urandom_range(0, ready_codes.size() - 1)],
               $urandom, $urandom);
  endtask

  task automatic queue_glyph(input int g);
    for (int i = 0; i < GLYPH_BYTES; i++)
      queue_beat(CMD_LOAD, $urandom, g * GLYPH_BYTES + i, $urandom);
  endtask

  // mostly strings of draws, with begins, glyph reloads, stray writes and ignored commands
  task automatic queue_mix(input int n);
    int done, pick;
    done = 0;
    if ($urandom_range(0, 3) != 0) queue_beat(CMD_BEGIN, $urandom, $urandom, $urandom);
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        queue_draw();
      end else if (pick < 70) begin
        queue_beat(CMD_BEGIN, $urandom, $urandom, $urandom);
      end else if (pick < 75) begin
        queue_glyph($urandom_range(0, GLYPHS - 1));
        done += GLYPH_BYTES - 1;
      end else if (pick < 90) begin
        queue_beat(CMD_LOAD, $urandom, $urandom_range(0, ADDR_MAX), $urandom);
      end else begin
        queue_beat(CMD_IGNORED, $urandom, $urandom, $urandom);
      end
      done++;
    end
  endtask

  // sender pause: everything sent, every row seen, block left to settle
  task automatic wait_idle();
    do @(negedge clk);
    while (beats_to_send.size() != 0 || in_valid || rows_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // input beats: random idle bursts after a beat unless quiet, payload held while stalled
  always @(posedge clk) begin : beat_drive
    beat_t taken;
    beat_t nxt;
    logic send;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken = '{in_command, in_char_code, in_font_address, in_font_byte};
        glyph_rows_for(taken);
      end
      if (!in_valid || !in_stall) begin
        send = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (beats_to_send.size() > 0) begin
          nxt = beats_to_send.pop_front();
          in_command      <= nxt.command;
          in_char_code    <= nxt.char_code;
          in_font_address <= nxt.font_address;
          in_font_byte    <= nxt.font_byte;
          send = 1'b1;
          if (!quiet) begin
            if (run_left > 0) run_left--;
            else if ($urandom_range(0, 1) == 0) gap_left = $urandom_range(1, 16);
            else run_left = $urandom_range(1, 32);
          end
        end
        in_valid <= send;
      end
    end
  end

  // row beats checked against the oldest prediction; stall pacing on the same edge
  always @(posedge clk) begin : row_check
    row_t got;
    row_t want;
    logic hold_next;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_pixel_x, out_pixel_y, out_row_mask, out_row_width, out_last_row,
              out_text_halted};
      if (rows_due.size() == 0) begin
        $error("row beat with nothing pending: pixel_x %0d pixel_y %0d",
               got.pixel_x, got.pixel_y);
        error_count++;
      end else begin
        want = rows_due.pop_front();
        if (got.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
          error_count++;
        end
        if (got.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
          error_count++;
        end
        if (got.row_mask !== want.row_mask) begin
          $error("row_mask: expected %h, got %h", want.row_mask, got.row_mask);
          error_count++;
        end
        if (got.row_width !== want.row_width) begin
          $error("row_width: expected %0d, got %0d", want.row_width, got.row_width);
          error_count++;
        end
        if (got.last_row !== want.last_row) begin
          $error("last_row: expected %0d, got %0d", want.last_row, got.last_row);
          error_count++;
        end
        if (got.text_halted !== want.text_halted) begin
          $error("text_halted: expected %0d, got %0d", want.text_halted, got.text_halted);
          error_count++;
        end
      end
    end
    // long hold-off on request, otherwise stall bursts between free-running stretches, none when quiet
    if (hold_seen != hold_kick) begin
      hold_seen = hold_kick;
      hold_left = LONG_HOLD;
    end
    if (!rst_n) begin
      hold_next = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      hold_next = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      hold_next = 1'b1;
    end else if (flow_left > 0 || quiet) begin
      if (flow_left > 0) flow_left--;
      hold_next = 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      hold_next = 1'b1;
    end else begin
      flow_left = $urandom_range(1, 40);
      hold_next = 1'b0;
    end
    out_stall <= hold_next;
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bitmap_text_rasterizer test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [SCALE_W-1:0] sc;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: corner glyph, writes past the font, ignored command,
    // draw before any begin, then the top glyph up to the last font byte
    for (int i = 0; i < GLYPH_BYTES; i++)
      queue_beat(CMD_LOAD, 0, i, CORNER_GLYPH[(GLYPH_BYTES - 1 - i) * 8 +: 8]);
    queue_beat(CMD_LOAD, 8'hFF, FONT_BYTES, 8'hFF);
    queue_beat(CMD_LOAD, 8'h00, ADDR_MAX, 8'h00);
    queue_beat(CMD_IGNORED, 8'hFF, ADDR_MAX, 8'hFF);
    queue_beat(CMD_DRAW, 0, 0, 0);
    queue_beat(CMD_BEGIN, 0, 0, 0);
    queue_beat(CMD_DRAW, 0, 0, 0);
    queue_glyph(GLYPHS - 1);
    queue_beat(CMD_DRAW, GLYPHS - 1, ADDR_MAX, 8'hFF);
    queue_beat(CMD_DRAW, 0, 0, 0);
    wait_idle();

    // largest scale in a tight window: wraps, halts, draws while halted, restart;
    // receiver holds off meanwhile so the block backs up into its input
    set_window(0, 0, 64, 100, 1'b1, 3'd4);
    @(negedge clk);
    hold_kick++;
    queue_beat(CMD_BEGIN, $urandom, $urandom, $urandom);
    repeat (8) queue_draw();
    queue_beat(CMD_BEGIN, $urandom, $urandom, $urandom);
    queue_draw();
    wait_idle();

    // single line near the right edge: partial fit then halt
    set_window(1000, 5, 1023, 1023, 1'b0, 3'd2);
    @(negedge clk);
    queue_beat(CMD_BEGIN, $urandom, $urandom, $urandom);
    repeat (4) queue_draw();
    wait_idle();

    // every coordinate at its top, scale zero taken as one
    set_window(1023, 1023, 1023, 1023, 1'b1, 3'd0);
    @(negedge clk);
    queue_beat(CMD_BEGIN, $urandom, $urandom, $urandom);
    repeat (2) queue_draw();
    wait_idle();

    // zero-size window, scale above the maximum
    set_window(0, 0, 0, 0, 1'b1, 3'd7);
    @(negedge clk);
    queue_beat(CMD_BEGIN, $urandom, $urandom, $urandom);
    repeat (2) queue_draw();
    wait_idle();

    // scale changed in the middle of a string, no new begin
    set_window(100, 200, 1023, 1023, 1'b1, 3'd3);
    @(negedge clk);
    queue_beat(CMD_BEGIN, $urandom, $urandom, $urandom);
    repeat (3) queue_draw();
    wait_idle();
    write_reg(REG_SCALE, CFG_W'(2));
    @(negedge clk);
    repeat (3) queue_draw();
    wait_idle();

    // random windows and scales; the last phase runs without idling
    for (int p = 0; p < 4; p++) begin
      if ($urandom_range(0, 4) == 0) sc = SCALE_W'($urandom_range(0, 7));
      else sc = SCALE_W'($urandom_range(1, SCALE_MAX));
      set_window($urandom_range(0, 700), $urandom_range(0, 700), $urandom_range(0, 1023),
                 $urandom_range(200, 1023), $urandom_range(0, 1), sc);
      @(negedge clk);
      if (p == 3) quiet = 1'b1;
      queue_mix(17);
      wait_idle();
    end

    if (error_count == 0 && rows_due.size() == 0)
      $display("bitmap_text_rasterizer test passed");
    else
      $display("bitmap_text_rasterizer test failed");
    $finish;
  end

endmodule
